// ===== rtl/incremental_weighted_mean_defines.svh =====
// Assertion macros shared by the incremental weighted mean RTL.
// Expects a clock named clk and an active-low reset named arst_n in scope.
`ifndef INCREMENTAL_WEIGHTED_MEAN_DEFINES_SVH
`define INCREMENTAL_WEIGHTED_MEAN_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define IWM_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("iwm: same-cycle check failed");

// Next-cycle implication, checked outside reset
`define IWM_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("iwm: next-cycle check failed");

`endif

// ===== rtl/iwm_pkg.sv =====
// Package for the incremental weighted mean block: payload types, widths,
// controller state encoding and the command/status structs. No dependencies.
`default_nettype none

package iwm_pkg;

	// quotient fraction bits of weight / sum
	localparam int QFB = 24;
	localparam int CNT_W = $clog2(QFB);
	localparam int W_W = 17;              // |weight| up to 32768
	localparam int PROD_W = QFB + 34;     // 33-bit diff times (QFB+1)-bit quotient
	localparam logic [W_W-1:0] UNIT_WEIGHT = W_W'(256);

	typedef struct packed {
		logic signed [31:0] sample;
		logic signed [15:0] weight;
		logic               last;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] mean;
		logic               status;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START,
		ST_DIV,
		ST_MUL,
		ST_UPD,
		ST_FIN
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;       // latch incoming item
		logic seed;       // first weighted item seeds mean and sum
		logic start_div;  // update sum, start quotient
		logic div_step;   // one quotient bit
		logic mul;        // q * (sample - mean)
		logic upd;        // apply step to mean
		logic emit;       // load result register, clear set state
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic seeded;
		logic w_zero;
		logic last;
		logic div_done;
	} dp_stat_t;

endpackage

`default_nettype wire

// ===== rtl/incremental_weighted_mean.sv =====
// Incremental weighted mean of a set of Q16.16 samples with Q8.8 weights.
// Channels: src (sample, weight, last) and dst (mean, status) use valid and
// stall; a transfer happens when valid is high and stall is low. cfg is a
// valid/ready write port for the weight enable; ready is always high. The user
// makes writes only while the block is idle; the block itself does not enforce it.
// Flow: one item at a time. After a transfer, src stays stalled while the item
// passes ST_START and ST_FIN when it seeds or is skipped, and ST_START, the
// divider steps, ST_MUL, ST_UPD and ST_FIN once seeded; the restoring divider
// produces one quotient bit per cycle.
// A last item loads the result register in ST_FIN, after the update if there
// was one, once the register is free to take it.
// If dst stalls, the result is held; the next item is still accepted and
// processed, and only a following last item waits for the register to drain.
// Reset clears the mean, the weight sum, the seeded flag and the weight enable.
// Depends on iwm_pkg, iwm_ctrl, iwm_dp and the assertion macro header.
`default_nettype none
`include "incremental_weighted_mean_defines.svh"

module incremental_weighted_mean (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 cfg_valid,
	output logic                cfg_ready,
	input  wire                 cfg_data,
	input  wire                 src_valid,
	output logic                src_stall,
	input  iwm_pkg::in_item_t   src_item,
	output logic                dst_valid,
	input  wire                 dst_stall,
	output iwm_pkg::out_item_t  dst_item
);
	import iwm_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	assign cfg_ready = 1'b1;

	iwm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_stall (src_stall),
		.dst_valid (dst_valid),
		.dst_stall (dst_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	iwm_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wr   (cfg_valid && cfg_ready),
		.cfg_data (cfg_data),
		.src_item (src_item),
		.cmd      (cmd),
		.stat     (stat),
		.dst_item (dst_item)
	);

	// checks
	`IWM_ASSERT_NEXT(a_busy_after_transfer, src_valid && !src_stall, src_stall)
	`IWM_ASSERT_NOW(a_emit_slot_free, cmd.emit, !dst_valid || !dst_stall)
	`IWM_ASSERT_NOW(a_div_needs_seed, cmd.start_div || cmd.div_step, stat.seeded)
	`IWM_ASSERT_NOW(a_error_mean_zero, dst_valid && dst_item.status, dst_item.mean == 32'sd0)

endmodule

`default_nettype wire

// ===== rtl/iwm_ctrl.sv =====
// Controller of the incremental weighted mean: sequences one item at a time
// and owns the input stall and output valid. Depends on iwm_pkg.
`default_nettype none

module iwm_ctrl (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 src_valid,
	output logic                src_stall,
	output logic                dst_valid,
	input  wire                 dst_stall,
	input  iwm_pkg::dp_stat_t   stat,
	output iwm_pkg::dp_cmd_t    cmd
);
	import iwm_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   slot_free;

	assign slot_free = !out_valid_q || !dst_stall;
	assign src_stall = (state_q != ST_IDLE);
	assign dst_valid = out_valid_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (src_valid) state_d = ST_START;
			end
			ST_START: begin
				state_d = stat.seeded ? ST_DIV : ST_FIN;
			end
			ST_DIV: begin
				if (stat.div_done) state_d = ST_MUL;
			end
			ST_MUL: begin
				state_d = ST_UPD;
			end
			ST_UPD: begin
				state_d = ST_FIN;
			end
			ST_FIN: begin
				if (!stat.last || slot_free) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// commands
	always_comb begin
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				cmd.load = src_valid;
			end
			ST_START: begin
				cmd.seed      = !stat.seeded && !stat.w_zero;
				cmd.start_div = stat.seeded;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
			end
			ST_UPD: begin
				cmd.upd = 1'b1;
			end
			ST_FIN: begin
				cmd.emit = stat.last && slot_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	// state and result-valid registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (!dst_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/iwm_dp.sv =====
// Datapath of the incremental weighted mean: mean and weight sum registers,
// restoring divider, multiplier and result register. Depends on iwm_pkg.
`default_nettype none

module iwm_dp (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 cfg_wr,
	input  wire                 cfg_data,
	input  iwm_pkg::in_item_t   src_item,
	input  iwm_pkg::dp_cmd_t    cmd,
	output iwm_pkg::dp_stat_t   stat,
	output iwm_pkg::out_item_t  dst_item
);
	import iwm_pkg::*;

	logic                     weight_en_q;
	logic signed [31:0]       sample_q;
	logic [W_W-1:0]           w_q;
	logic                     last_q;
	logic signed [31:0]       mean_q;
	logic [31:0]              total_q;
	logic                     seeded_q;
	logic [31:0]              rem_q;
	logic [QFB-1:0]           quo_q;
	logic [CNT_W-1:0]         cnt_q;
	logic signed [PROD_W-1:0] prod_q;
	out_item_t                out_q;

	logic [W_W-1:0]           w_in;
	logic [32:0]              sum_ext;
	logic [31:0]              sum_sat;
	logic [32:0]              rem_dbl;
	logic                     quo_bit;
	logic [32:0]              rem_sub;
	logic signed [32:0]       diff;
	logic signed [PROD_W-1:0] prod_c;
	logic signed [PROD_W-1:0] step_full;

	// effective weight of the incoming item
	always_comb begin
		if (!weight_en_q) begin
			w_in = UNIT_WEIGHT;
		end else if (src_item.weight[15]) begin
			w_in = W_W'(17'h10000) - {1'b0, src_item.weight};
		end else begin
			w_in = {1'b0, src_item.weight};
		end
	end

	// saturating weight sum
	assign sum_ext = {1'b0, total_q} + 33'(w_q);
	assign sum_sat = sum_ext[32] ? 32'hFFFF_FFFF : sum_ext[31:0];

	// one restoring division step against the updated sum
	assign rem_dbl = {rem_q, 1'b0};
	assign quo_bit = (rem_dbl >= {1'b0, total_q});
	assign rem_sub = rem_dbl - {1'b0, total_q};

	// signed product q * (sample - mean); floor shift on update
	assign diff      = $signed({sample_q[31], sample_q}) - $signed({mean_q[31], mean_q});
	assign prod_c    = diff * $signed({1'b0, quo_q});
	assign step_full = prod_q >>> QFB;

	assign stat.seeded   = seeded_q;
	assign stat.w_zero   = (w_q == '0);
	assign stat.last     = last_q;
	assign stat.div_done = (cnt_q == CNT_W'(QFB - 1));
	assign dst_item      = out_q;

	// control-like state with reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weight_en_q <= 1'b0;
			last_q      <= 1'b0;
			mean_q      <= '0;
			total_q     <= '0;
			seeded_q    <= 1'b0;
		end else begin
			if (cfg_wr) weight_en_q <= cfg_data;
			if (cmd.load) last_q <= src_item.last;
			if (cmd.seed) begin
				mean_q   <= sample_q;
				total_q  <= 32'(w_q);
				seeded_q <= 1'b1;
			end
			if (cmd.start_div) total_q <= sum_sat;
			if (cmd.upd) mean_q <= mean_q + step_full[31:0];
			if (cmd.emit) begin
				mean_q   <= '0;
				total_q  <= '0;
				seeded_q <= 1'b0;
			end
		end
	end

	// payload and working registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sample_q <= src_item.sample;
			w_q      <= w_in;
		end
		if (cmd.start_div) begin
			rem_q <= 32'(w_q);
			quo_q <= '0;
			cnt_q <= '0;
		end
		if (cmd.div_step) begin
			rem_q <= quo_bit ? rem_sub[31:0] : rem_dbl[31:0];
			quo_q <= {quo_q[QFB-2:0], quo_bit};
			cnt_q <= cnt_q + CNT_W'(1);
		end
		if (cmd.mul) prod_q <= prod_c;
		if (cmd.emit) begin
			out_q.mean   <= seeded_q ? mean_q : 32'sd0;
			out_q.status <= !seeded_q;
		end
	end

endmodule

`default_nettype wire
